// ===== design/pid_sir_pkg.sv =====
// ----------------------------------------------------------------------------
// PID step controller package
// Shared widths, register indexes, configuration and term types, and the
// saturation helpers used by the datapath stages.
// ----------------------------------------------------------------------------
package pid_sir_pkg;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 31;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = GAIN_W + DATA_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int OUT_W   = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_DT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_PER_DT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT     = 2'd3;

    // Reset value of the sum limit: 500.0 in Q16.16.
    localparam logic [LIMIT_W-1:0] SUM_LIMIT_RESET = 31'd32768000;

    // Rounding bias: one half in the product's fraction position.
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);

    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i_dt;
        logic [GAIN_W-1:0]  gain_d_per_dt;
        logic [LIMIT_W-1:0] sum_limit;
    } pid_cfg_t;

    // Terms handed from the state update stage to the multiply stage.
    typedef struct packed {
        logic [DATA_W-1:0] error;
        logic [DATA_W-1:0] error_sum;
        logic [DATA_W-1:0] error_delta;
    } pid_terms_t;

    // Saturate a 33-bit two's complement value to 32 bits.
    function automatic logic [DATA_W-1:0] sat_data(input logic [DATA_W:0] v);
        logic [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Saturate the rounded output word to 32 bits.
    function automatic logic [DATA_W-1:0] sat_out(input logic [OUT_W-1:0] v);
        logic [DATA_W-1:0] r;
        if ((&v[OUT_W-1:DATA_W-1]) || !(|v[OUT_W-1:DATA_W-1]))
        begin
            r = v[DATA_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

endpackage

// ===== design/pid_sir_cfg.sv =====
// ----------------------------------------------------------------------------
// PID configuration registers
// Holds the three gains and the error sum limit, written by index.
// ----------------------------------------------------------------------------
module pid_sir_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [pid_sir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pid_sir_pkg::LIMIT_W-1:0]        cfg_data,
    output pid_sir_pkg::pid_cfg_t                  cfg
);
    import pid_sir_pkg::*;

    pid_cfg_t cfg_reg;

    // Register file write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= '0;
            cfg_reg.gain_i_dt     <= '0;
            cfg_reg.gain_d_per_dt <= '0;
            cfg_reg.sum_limit     <= SUM_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P:        cfg_reg.gain_p        <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I_DT:     cfg_reg.gain_i_dt     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D_PER_DT: cfg_reg.gain_d_per_dt <= cfg_data[GAIN_W-1:0];
                REG_SUM_LIMIT:     cfg_reg.sum_limit     <= cfg_data;
                default:           cfg_reg.sum_limit     <= cfg_reg.sum_limit;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pid_sir_front.sv =====
// ----------------------------------------------------------------------------
// PID input register and state update
// Registers the incoming word, then forms the error, applies the sum limit
// reset and updates the error sum, last error and error difference.
// ----------------------------------------------------------------------------
module pid_sir_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pid_sir_pkg::DATA_W-1:0]         target_value,
    input  logic [pid_sir_pkg::DATA_W-1:0]         measured_value,
    input  logic [pid_sir_pkg::LIMIT_W-1:0]        sum_limit,
    output logic                                   terms_valid,
    input  logic                                   terms_ready,
    output pid_sir_pkg::pid_terms_t                terms
);
    import pid_sir_pkg::*;

    logic              in_v_reg;
    logic              in_v_next;
    logic [DATA_W-1:0] target_reg;
    logic [DATA_W-1:0] measured_reg;

    logic              terms_v_reg;
    logic              terms_v_next;
    pid_terms_t        terms_reg;
    pid_terms_t        terms_next;

    logic [DATA_W-1:0] error_sum_reg;
    logic [DATA_W-1:0] last_error_reg;
    logic [DATA_W-1:0] error_delta_reg;
    logic              first_sample_reg;

    logic              ready_in;
    logic              ready_terms;
    logic              load_in;
    logic              move_terms;

    logic [DATA_W:0]   sum_abs;
    logic              clear_state;
    logic [DATA_W-1:0] base_sum;
    logic [DATA_W-1:0] base_last;
    logic              first_now;
    logic [DATA_W-1:0] error_new;
    logic [DATA_W-1:0] sum_new;
    logic [DATA_W-1:0] diff_new;
    logic [DATA_W-1:0] delta_new;

    // Handshake: each stage moves on when the next one is empty or moving.
    assign ready_terms = !terms_v_reg || terms_ready;
    assign ready_in    = !in_v_reg || ready_terms;
    assign in_stall    = !ready_in;
    assign load_in     = in_valid && ready_in;
    assign move_terms  = in_v_reg && ready_terms;

    assign in_v_next    = load_in || (in_v_reg && !ready_terms);
    assign terms_v_next = move_terms || (terms_v_reg && !terms_ready);

    // Limit check on the stored sum; equality does not clear.
    always_comb
    begin
        sum_abs     = error_sum_reg[DATA_W-1] ? ((DATA_W+1)'(0) - {1'b1, error_sum_reg})
                                              : {1'b0, error_sum_reg};
        clear_state = sum_abs > {2'b00, sum_limit};
        base_sum    = clear_state ? '0 : error_sum_reg;
        base_last   = clear_state ? '0 : last_error_reg;
        first_now   = clear_state || first_sample_reg;
    end

    // Error, running sum and difference, each saturated to 32 bits.
    always_comb
    begin
        error_new = sat_data({target_reg[DATA_W-1], target_reg}
                             - {measured_reg[DATA_W-1], measured_reg});
        sum_new   = sat_data({base_sum[DATA_W-1], base_sum}
                             + {error_new[DATA_W-1], error_new});
        diff_new  = sat_data({error_new[DATA_W-1], error_new}
                             - {base_last[DATA_W-1], base_last});
        delta_new = first_now ? error_delta_reg : diff_new;

        terms_next.error       = error_new;
        terms_next.error_sum   = sum_new;
        terms_next.error_delta = delta_new;
    end

    // Handshake valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            terms_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg    <= in_v_next;
            terms_v_reg <= terms_v_next;
        end
    end

    // Controller state, updated once per word as it leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg    <= '0;
            last_error_reg   <= '0;
            error_delta_reg  <= '0;
            first_sample_reg <= 1'b1;
        end
        else if (move_terms)
        begin
            error_sum_reg    <= sum_new;
            last_error_reg   <= error_new;
            error_delta_reg  <= delta_new;
            first_sample_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            target_reg   <= target_value;
            measured_reg <= measured_value;
        end
        if (move_terms)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms_valid = terms_v_reg;
    assign terms       = terms_reg;

endmodule

// ===== design/pid_sir_mac.sv =====
// ----------------------------------------------------------------------------
// PID multiply and output stage
// Multiplies each term by its gain, then adds the products, rounds to
// Q16.16 and saturates into the output register.
// ----------------------------------------------------------------------------
module pid_sir_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pid_sir_pkg::pid_cfg_t                  cfg,
    input  logic                                   terms_valid,
    output logic                                   terms_ready,
    input  pid_sir_pkg::pid_terms_t                terms,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [pid_sir_pkg::DATA_W-1:0]         drive_value
);
    import pid_sir_pkg::*;

    logic              prod_v_reg;
    logic              prod_v_next;
    logic [PROD_W-1:0] prod_p_reg;
    logic [PROD_W-1:0] prod_i_reg;
    logic [PROD_W-1:0] prod_d_reg;
    logic [PROD_W-1:0] prod_p_next;
    logic [PROD_W-1:0] prod_i_next;
    logic [PROD_W-1:0] prod_d_next;

    logic              out_v_reg;
    logic              out_v_next;
    logic [DATA_W-1:0] drive_reg;
    logic [DATA_W-1:0] drive_next;

    logic              ready_out;
    logic              move_prod;
    logic              move_out;
    logic [ACC_W-1:0]  acc;
    logic [OUT_W-1:0]  rounded;

    // Handshake.
    assign ready_out   = !out_v_reg || !out_stall;
    assign terms_ready = !prod_v_reg || ready_out;
    assign move_prod   = terms_valid && terms_ready;
    assign move_out    = prod_v_reg && ready_out;

    assign prod_v_next = move_prod || (prod_v_reg && !ready_out);
    assign out_v_next  = move_out || (out_v_reg && out_stall);

    // Three signed products; the low PROD_W bits of a sign-extended product are exact.
    always_comb
    begin
        prod_p_next = {{DATA_W{cfg.gain_p[GAIN_W-1]}}, cfg.gain_p}
                      * {{GAIN_W{terms.error[DATA_W-1]}}, terms.error};
        prod_i_next = {{DATA_W{cfg.gain_i_dt[GAIN_W-1]}}, cfg.gain_i_dt}
                      * {{GAIN_W{terms.error_sum[DATA_W-1]}}, terms.error_sum};
        prod_d_next = {{DATA_W{cfg.gain_d_per_dt[GAIN_W-1]}}, cfg.gain_d_per_dt}
                      * {{GAIN_W{terms.error_delta[DATA_W-1]}}, terms.error_delta};
    end

    // Sum, round half up, drop the extra fraction bits and saturate.
    always_comb
    begin
        acc = {{2{prod_p_reg[PROD_W-1]}}, prod_p_reg}
              + {{2{prod_i_reg[PROD_W-1]}}, prod_i_reg}
              + {{2{prod_d_reg[PROD_W-1]}}, prod_d_reg}
              + ROUND_BIAS;
        rounded    = acc[ACC_W-1:FRAC_W];
        drive_next = sat_out(rounded);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            prod_v_reg <= prod_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (move_prod)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (move_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid   = out_v_reg;
    assign drive_value = drive_reg;

endmodule

// ===== design/pid_step_integral_reset.sv =====
// A word accepted into the input register moves through the terms, product and output registers;
// out_valid then rises; the word leaves when out_stall is low. Throughput: one word per
// cycle while out_stall is low; the state update (error, limit check, sum) is a single stage.
// The gain multiplies and the final add with rounding each have their own register stage.
// Reset clears the error sum, last error and difference, sets the first-sample flag,
// zeroes the gains and sets the sum limit to 500.0; all pipeline stages come up empty.
// ----------------------------------------------------------------------------
// PID step controller with integral reset
// Discrete PID with step time folded into the gains; the error sum and the
// previous error are cleared when the sum magnitude exceeds a limit.
// ----------------------------------------------------------------------------
module pid_step_integral_reset (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [pid_sir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pid_sir_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pid_sir_pkg::DATA_W-1:0]         target_value,
    input  logic [pid_sir_pkg::DATA_W-1:0]         measured_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [pid_sir_pkg::DATA_W-1:0]         drive_value
);
    import pid_sir_pkg::*;

    pid_cfg_t   cfg;
    pid_terms_t terms;
    logic       terms_valid;
    logic       terms_ready;

    // Configuration registers.
    pid_sir_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and controller state.
    pid_sir_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_value   (target_value),
        .measured_value (measured_value),
        .sum_limit      (cfg.sum_limit),
        .terms_valid    (terms_valid),
        .terms_ready    (terms_ready),
        .terms          (terms)
    );

    // Gain products and output word.
    pid_sir_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive_value (drive_value)
    );

endmodule
